### hw/rtl/ffha_pkg.sv
package ffha_pkg;

  // field widths
  localparam int ADDR_W = 23;
  localparam int DATA_W = 22;
  localparam int AMNT_W = ADDR_W + 1;
  localparam int CIDX_W = 3;

  // operation codes
  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADADDR = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_MEM_START  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_HOLE_START = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_HOLE_END   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_MEM_END    = 3'd3;

  // configuration reset values
  localparam logic [ADDR_W-1:0] RST_MEM_START  = 23'd131072;
  localparam logic [ADDR_W-1:0] RST_HOLE_START = 23'd655360;
  localparam logic [ADDR_W-1:0] RST_HOLE_END   = 23'd1048576;
  localparam logic [ADDR_W-1:0] RST_MEM_END    = 23'd4194304;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    cnt_clr;
    logic    rnd;
    logic    fscan;
    logic    uscan;
    logic    awrite;
    logic    usrch;
    logic    fsrch;
    logic    fwrite;
    logic    init1;
    logic    init2;
    logic    res_load;
    status_t res_status;
    logic    res_alloc;
    logic    out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       fa_zero;
    logic       rnd_last;
    logic       fdone;
    logic       udone;
    logic       udone_rd;
    logic       best_found;
    logic       u_found;
    logic       match;
    logic       fw_ok;
    logic       out_busy;
  } sts_t;

endpackage

### hw/rtl/ffha_ram.sv
module ffha_ram #(
  parameter int WIDTH = 46,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### hw/rtl/ffha_ctrl.sv
module ffha_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  ffha_pkg::sts_t sts,
  output ffha_pkg::cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DISP   = 13'b0000000000010,
    S_INIT1  = 13'b0000000000100,
    S_INIT2  = 13'b0000000001000,
    S_RND    = 13'b0000000010000,
    S_FSCAN  = 13'b0000000100000,
    S_USCAN  = 13'b0000001000000,
    S_AWRITE = 13'b0000010000000,
    S_USRCH  = 13'b0000100000000,
    S_FSRCH  = 13'b0001000000000,
    S_FWRITE = 13'b0010000000000,
    S_DONE   = 13'b0100000000000,
    S_SPARE  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.res_status = ffha_pkg::ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.cnt_clr = 1'b1;
        unique case (sts.op)
          ffha_pkg::OP_INIT:  state_nxt = S_INIT1;
          ffha_pkg::OP_ALLOC: state_nxt = S_RND;
          ffha_pkg::OP_FREE: begin
            if (sts.fa_zero) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ffha_pkg::ST_BADADDR;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_USRCH;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_INIT1: begin
        cmd.init1 = 1'b1;
        state_nxt = S_INIT2;
      end
      S_INIT2: begin
        cmd.init2 = 1'b1;
        state_nxt = S_DONE;
      end
      S_RND: begin
        cmd.rnd = 1'b1;
        if (sts.rnd_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_FSCAN;
        end
      end
      S_FSCAN: begin
        cmd.fscan = 1'b1;
        if (sts.fdone) begin
          cmd.cnt_clr = 1'b1;
          if (sts.best_found) begin
            state_nxt = S_USCAN;
          end else begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ffha_pkg::ST_NOFIT;
            state_nxt      = S_DONE;
          end
        end
      end
      S_USCAN: begin
        cmd.uscan = 1'b1;
        if (sts.u_found) begin
          state_nxt = S_AWRITE;
        end else if (sts.udone) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ffha_pkg::ST_FULL;
          state_nxt      = S_DONE;
        end
      end
      S_AWRITE: begin
        cmd.awrite    = 1'b1;
        cmd.res_load  = 1'b1;
        cmd.res_alloc = 1'b1;
        state_nxt     = S_DONE;
      end
      S_USRCH: begin
        cmd.usrch = 1'b1;
        if (sts.udone_rd) begin
          cmd.cnt_clr = 1'b1;
          if (sts.match) begin
            state_nxt = S_FSRCH;
          end else begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ffha_pkg::ST_BADADDR;
            state_nxt      = S_DONE;
          end
        end
      end
      S_FSRCH: begin
        cmd.fsrch = 1'b1;
        if (sts.fdone) begin
          state_nxt = S_FWRITE;
        end
      end
      S_FWRITE: begin
        cmd.fwrite     = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = sts.fw_ok ? ffha_pkg::ST_OK : ffha_pkg::ST_FULL;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // done and allocate-write states hand on as expected; items are taken only in idle
  a_done_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && !sts.out_busy |=> (state_r == S_IDLE))
    else $error("done state did not hand off result");
  a_awrite_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AWRITE) |=> (state_r == S_DONE))
    else $error("allocate write not followed by done");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == S_IDLE))
    else $error("item taken outside idle");

endmodule

### hw/rtl/ffha_dp.sv
module ffha_dp #(
  parameter int FREE_SLOTS   = 32,
  parameter int USED_SLOTS   = 64,
  parameter int HEADER_BYTES = 16,
  parameter int ALIGN_BYTES  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [47:0]                     in_tdata,
  input  logic [1:0]                      in_tuser,
  input  logic                            cfg_valid,
  input  logic [ffha_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [ffha_pkg::ADDR_W-1:0]     cfg_data,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,
  output logic [1:0]                      out_tuser,
  input  ffha_pkg::cmd_t                  cmd,
  output ffha_pkg::sts_t                  sts
);

  localparam int A     = ffha_pkg::ADDR_W;
  localparam int AW    = ffha_pkg::AMNT_W;
  localparam int FIDX_W = $clog2(FREE_SLOTS);
  localparam int UIDX_W = $clog2(USED_SLOTS > 1 ? USED_SLOTS : 2);
  localparam int MAXN  = (FREE_SLOTS > USED_SLOTS) ? FREE_SLOTS : USED_SLOTS;
  localparam int CNT_W = $clog2(MAXN + 1) > 5 ? $clog2(MAXN + 1) : 5;
  localparam int REM_W = $clog2(ALIGN_BYTES + 1);
  // reciprocal of the alignment, scaled by 2^AW
  localparam longint RECIP = (longint'(1) << AW) / ALIGN_BYTES;

  // configuration registers
  logic [A-1:0] ms_r, hs_r, he_r, me_r;

  // request and rounding
  logic [1:0]               op_r;
  logic [A-1:0]             req_r, q_r;
  logic [A+AW:0]            prod;
  logic [A-1:0]             rem_est, rem_nxt;
  logic [ffha_pkg::DATA_W-1:0] fa_r;
  logic [REM_W-1:0]         rem_r;
  logic [REM_W-1:0]         pad;
  logic [AW-1:0]            amnt_r;

  // scan control
  logic [CNT_W-1:0] cnt_r, idx_d_r;
  logic             pipe_r;
  logic             f_lt, u_lt;

  // valid bits
  logic [FREE_SLOTS-1:0] fvalid_r;
  logic [USED_SLOTS-1:0] uvalid_r;

  // scan findings
  logic              best_found_r, u_found_r, match_r;
  logic [FIDX_W-1:0] best_idx_r;
  logic [A-1:0]      best_base_r, best_len_r;
  logic [UIDX_W-1:0] u_idx_r;
  logic [A-1:0]      m_base_r, m_len_r;
  logic              left_r, right_r, empty_r, e1_r;
  logic [FIDX_W-1:0] left_idx_r, right_idx_r, empty_idx_r;
  logic [A-1:0]      left_base_r, left_len_r, right_len_r;

  // results
  logic [ffha_pkg::DATA_W-1:0] res_addr_r, out_addr_r;
  ffha_pkg::status_t           res_status_r, out_status_r;
  logic                        out_valid_r;

  // ram ports
  logic              fw_en, uw_en;
  logic [FIDX_W-1:0] fw_addr;
  logic [UIDX_W-1:0] uw_addr;
  logic [2*A-1:0]    fw_data, f_rdata, u_rdata;
  logic [A-1:0]      fb, fl, ub, ul, a_sum;
  logic [AW-1:0]     f_end, m_end;
  logic              f_vld_d, u_vld_d;

  ffha_ram #(.WIDTH(2*A), .DEPTH(FREE_SLOTS)) u_free_ram (
    .clk   (clk),
    .we    (fw_en),
    .waddr (fw_addr),
    .wdata (fw_data),
    .raddr (cnt_r[FIDX_W-1:0]),
    .rdata (f_rdata)
  );

  ffha_ram #(.WIDTH(2*A), .DEPTH(USED_SLOTS)) u_used_ram (
    .clk   (clk),
    .we    (uw_en),
    .waddr (uw_addr),
    .wdata ({best_base_r, amnt_r[A-1:0]}),
    .raddr (cnt_r[UIDX_W-1:0]),
    .rdata (u_rdata)
  );

  assign fb = f_rdata[2*A-1:A];
  assign fl = f_rdata[A-1:0];
  assign ub = u_rdata[2*A-1:A];
  assign ul = u_rdata[A-1:0];
  assign f_end = {1'b0, fb} + {1'b0, fl};
  assign m_end = {1'b0, m_base_r} + {1'b0, m_len_r};
  assign f_lt  = cnt_r < CNT_W'(FREE_SLOTS);
  assign u_lt  = cnt_r < CNT_W'(USED_SLOTS);
  assign f_vld_d = fvalid_r[idx_d_r[FIDX_W-1:0]];
  assign u_vld_d = uvalid_r[idx_d_r[UIDX_W-1:0]];
  assign a_sum = best_base_r + A'(HEADER_BYTES);

  // remainder by reciprocal multiply, one correction step, rounding pad
  always_comb begin
    prod    = {{(AW+1){1'b0}}, req_r} * (A+AW+1)'(RECIP);
    rem_est = req_r - q_r * A'(ALIGN_BYTES);
    rem_nxt = (rem_est >= A'(ALIGN_BYTES)) ? rem_est - A'(ALIGN_BYTES) : rem_est;
    pad = (rem_r == '0) ? '0 : REM_W'(ALIGN_BYTES) - rem_r;
  end

  // free ram write port
  always_comb begin
    fw_en   = 1'b0;
    fw_addr = '0;
    fw_data = {ms_r, hs_r - ms_r};
    priority if (cmd.init1) begin
      fw_en = ms_r < hs_r;
    end else if (cmd.init2) begin
      fw_en   = he_r < me_r;
      fw_addr = e1_r ? FIDX_W'(1) : '0;
      fw_data = {he_r, me_r - he_r};
    end else if (cmd.awrite) begin
      fw_en   = 1'b1;
      fw_addr = best_idx_r;
      fw_data = {best_base_r + amnt_r[A-1:0], best_len_r - amnt_r[A-1:0]};
    end else if (cmd.fwrite) begin
      priority if (left_r) begin
        fw_en   = 1'b1;
        fw_addr = left_idx_r;
        fw_data = {left_base_r,
                   left_len_r + m_len_r + (right_r ? right_len_r : '0)};
      end else if (right_r) begin
        fw_en   = 1'b1;
        fw_addr = right_idx_r;
        fw_data = {m_base_r, right_len_r + m_len_r};
      end else if (empty_r) begin
        fw_en   = 1'b1;
        fw_addr = empty_idx_r;
        fw_data = {m_base_r, m_len_r};
      end
    end
  end

  assign uw_en   = cmd.awrite;
  assign uw_addr = u_idx_r;

  // status to controller
  always_comb begin
    sts.op         = op_r;
    sts.fa_zero    = (fa_r == '0);
    sts.rnd_last   = (cnt_r == CNT_W'(1));
    sts.fdone      = (cnt_r == CNT_W'(FREE_SLOTS)) && !pipe_r;
    sts.udone      = (cnt_r == CNT_W'(USED_SLOTS));
    sts.udone_rd   = (cnt_r == CNT_W'(USED_SLOTS)) && !pipe_r;
    sts.best_found = best_found_r;
    sts.u_found    = u_found_r;
    sts.match      = match_r;
    sts.fw_ok      = left_r || right_r || empty_r;
    sts.out_busy   = out_valid_r && !out_tready;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r <= ffha_pkg::RST_MEM_START;
      hs_r <= ffha_pkg::RST_HOLE_START;
      he_r <= ffha_pkg::RST_HOLE_END;
      me_r <= ffha_pkg::RST_MEM_END;
    end else if (cfg_valid) begin
      if (cfg_index == ffha_pkg::CFG_MEM_START)  ms_r <= cfg_data;
      if (cfg_index == ffha_pkg::CFG_HOLE_START) hs_r <= cfg_data;
      if (cfg_index == ffha_pkg::CFG_HOLE_END)   he_r <= cfg_data;
      if (cfg_index == ffha_pkg::CFG_MEM_END)    me_r <= cfg_data;
    end
  end

  // control state: counter, flags, valid bits, output beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      pipe_r       <= 1'b0;
      fvalid_r     <= '0;
      uvalid_r     <= '0;
      best_found_r <= 1'b0;
      u_found_r    <= 1'b0;
      match_r      <= 1'b0;
      left_r       <= 1'b0;
      right_r      <= 1'b0;
      empty_r      <= 1'b0;
      e1_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        best_found_r <= 1'b0;
        u_found_r    <= 1'b0;
        match_r      <= 1'b0;
        left_r       <= 1'b0;
        right_r      <= 1'b0;
        empty_r      <= 1'b0;
      end

      // scan counter and read pipe
      priority if (cmd.cnt_clr) begin
        cnt_r  <= '0;
        pipe_r <= 1'b0;
      end else if (cmd.rnd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (cmd.fscan || cmd.fsrch) begin
        pipe_r <= f_lt;
        if (f_lt) cnt_r <= cnt_r + 1'b1;
      end else if (cmd.usrch) begin
        pipe_r <= u_lt;
        if (u_lt) cnt_r <= cnt_r + 1'b1;
      end else if (cmd.uscan && !u_found_r && u_lt) begin
        cnt_r <= cnt_r + 1'b1;
      end

      // first empty used slot
      if (cmd.uscan && !u_found_r && u_lt && !uvalid_r[cnt_r[UIDX_W-1:0]]) begin
        u_found_r <= 1'b1;
      end
      // lowest based fitting extent
      if (cmd.fscan && pipe_r && f_vld_d && ({1'b0, fl} > amnt_r) &&
          (!best_found_r || fb < best_base_r)) begin
        best_found_r <= 1'b1;
      end
      // recorded block lookup
      if (cmd.usrch && pipe_r && !match_r && u_vld_d &&
          ({1'b0, ub} + AW'(HEADER_BYTES)) == AW'(fa_r)) begin
        match_r <= 1'b1;
      end
      // neighbour and empty slot search
      if (cmd.fsrch && pipe_r) begin
        if (f_vld_d) begin
          if (!left_r && f_end == {1'b0, m_base_r}) begin
            left_r <= 1'b1;
          end else if (!right_r && {1'b0, fb} == m_end) begin
            right_r <= 1'b1;
          end
        end else if (!empty_r) begin
          empty_r <= 1'b1;
        end
      end

      // valid bit updates
      if (cmd.init1) begin
        fvalid_r    <= {{(FREE_SLOTS-1){1'b0}}, ms_r < hs_r};
        uvalid_r    <= '0;
        e1_r        <= ms_r < hs_r;
      end
      if (cmd.init2 && fw_en) begin
        fvalid_r[fw_addr] <= 1'b1;
      end
      if (cmd.awrite) begin
        uvalid_r[u_idx_r] <= 1'b1;
      end
      if (cmd.fwrite && (left_r || right_r || empty_r)) begin
        uvalid_r[u_idx_r] <= 1'b0;
        if (left_r && right_r) begin
          fvalid_r[right_idx_r] <= 1'b0;
        end else if (!left_r && !right_r) begin
          fvalid_r[empty_idx_r] <= 1'b1;
        end
      end

      // output register
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_d_r <= cnt_r;
    q_r     <= prod[A+AW-1:AW];
    rem_r   <= rem_nxt[REM_W-1:0];
    amnt_r  <= {1'b0, req_r} + AW'(pad) + AW'(HEADER_BYTES);
    if (cmd.load) begin
      op_r         <= in_tuser;
      req_r        <= in_tdata[A-1:0];
      fa_r         <= in_tdata[A+ffha_pkg::DATA_W-1:A];
      res_addr_r   <= '0;
      res_status_r <= ffha_pkg::ST_OK;
    end
    if (cmd.uscan && !u_found_r && u_lt) begin
      u_idx_r <= cnt_r[UIDX_W-1:0];
    end
    if (cmd.fscan && pipe_r && f_vld_d && ({1'b0, fl} > amnt_r) &&
        (!best_found_r || fb < best_base_r)) begin
      best_idx_r  <= idx_d_r[FIDX_W-1:0];
      best_base_r <= fb;
      best_len_r  <= fl;
    end
    if (cmd.usrch && pipe_r && !match_r && u_vld_d &&
        ({1'b0, ub} + AW'(HEADER_BYTES)) == AW'(fa_r)) begin
      u_idx_r  <= idx_d_r[UIDX_W-1:0];
      m_base_r <= ub;
      m_len_r  <= ul;
    end
    if (cmd.fsrch && pipe_r) begin
      if (f_vld_d) begin
        if (!left_r && f_end == {1'b0, m_base_r}) begin
          left_idx_r  <= idx_d_r[FIDX_W-1:0];
          left_base_r <= fb;
          left_len_r  <= fl;
        end else if (!right_r && {1'b0, fb} == m_end) begin
          right_idx_r <= idx_d_r[FIDX_W-1:0];
          right_len_r <= fl;
        end
      end else if (!empty_r) begin
        empty_idx_r <= idx_d_r[FIDX_W-1:0];
      end
    end
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      res_addr_r   <= cmd.res_alloc ? a_sum[ffha_pkg::DATA_W-1:0] : '0;
    end
    if (cmd.out_load) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(24 - ffha_pkg::DATA_W){1'b0}}, out_addr_r};
  assign out_tuser  = out_status_r;

  // consistency of the table updates
  a_awrite_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.awrite |-> best_found_r && u_found_r)
    else $error("allocate write without a chosen extent and slot");
  a_awrite_mark: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.awrite |=> uvalid_r[$past(u_idx_r)])
    else $error("allocated block not recorded");
  a_merge_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fwrite && left_r && right_r |-> left_idx_r != right_idx_r)
    else $error("merge neighbours share one slot");
  a_init_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.init2 |=> $countones(fvalid_r) <= 2 && uvalid_r == '0)
    else $error("init left stale entries");

endmodule

### hw/rtl/first_fit_heap_allocator.sv
// First-fit heap allocator over a byte address space with a reserved hole.
// Requests arrive on the in_ stream: in_tuser carries the operation
// (init, allocate, free), in_tdata the request size and the address to free.
// Each request yields exactly one result beat on the out_ stream: the usable
// block address in out_tdata and the status code in out_tuser.
// The cfg_ channel writes the four region registers; it is always ready and
// should be used only while no request is in flight.
// One request at a time. Init writes the two region extents. Allocate rounds
// the size, then scans the free table with one ram read per cycle, then the
// used table with one slot check per cycle; free reads each entry of the used
// table and then of the free table. Both tables have one write port and one
// registered read port.
// The result sits in an output register; a new request is accepted while it
// waits, and a finished request holds in its done state while the receiver
// stalls. Reset loads the default region registers and leaves both tables
// empty: an init request is needed before any allocation succeeds.
module first_fit_heap_allocator #(
  parameter int FREE_SLOTS   = 32,
  parameter int USED_SLOTS   = 64,
  parameter int HEADER_BYTES = 16,
  parameter int ALIGN_BYTES  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // req_size[22:0], free_addr[44:23], zero pad
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // data_addr[21:0], zero pad
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [22:0] cfg_data
);

  ffha_pkg::cmd_t cmd;
  ffha_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffha_dp #(
    .FREE_SLOTS   (FREE_SLOTS),
    .USED_SLOTS   (USED_SLOTS),
    .HEADER_BYTES (HEADER_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

### tb/sv/first_fit_heap_allocator_checker.sv
`timescale 1ns / 1ps
module first_fit_heap_allocator_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [22:0] cfg_data,
  output int          fail_count,
  output int          pending_count
);

  localparam int NFREE = 32;
  localparam int NUSED = 64;
  localparam int HDR   = 16;
  localparam int ALN   = 16;

  typedef struct packed {
    logic [ffha_pkg::DATA_W-1:0] addr;
    ffha_pkg::status_t           status;
  } heap_result_t;

  logic [ffha_pkg::ADDR_W-1:0] reg_mem_start, reg_hole_start, reg_hole_end, reg_mem_end;
  logic [ffha_pkg::ADDR_W-1:0] ext_base [NFREE];
  logic [ffha_pkg::ADDR_W-1:0] ext_len  [NFREE];
  logic                        ext_live [NFREE];
  logic [ffha_pkg::ADDR_W-1:0] blk_base [NUSED];
  logic [ffha_pkg::ADDR_W-1:0] blk_len  [NUSED];
  logic                        blk_live [NUSED];
  heap_result_t                expected_results [$];

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic int open_extent_slot();
    for (int i = 0; i < NFREE; i++) if (!ext_live[i]) return i;
    return -1;
  endfunction

  function automatic void clear_tables();
    for (int i = 0; i < NFREE; i++) begin
      ext_base[i] = '0; ext_len[i] = '0; ext_live[i] = 1'b0;
    end
    for (int i = 0; i < NUSED; i++) begin
      blk_base[i] = '0; blk_len[i] = '0; blk_live[i] = 1'b0;
    end
  endfunction

  function automatic void place_extent(input logic [ffha_pkg::ADDR_W-1:0] lo,
                                       input logic [ffha_pkg::ADDR_W-1:0] hi);
    int s;
    if (hi <= lo) return;
    s = open_extent_slot();
    if (s < 0) return;
    ext_base[s] = lo;
    ext_len[s]  = hi - lo;
    ext_live[s] = 1'b1;
  endfunction

  function automatic heap_result_t carve_block(input logic [ffha_pkg::ADDR_W-1:0] req);
    heap_result_t r;
    longint amnt;
    int pick, u;
    r = '{addr: '0, status: ffha_pkg::ST_OK};
    amnt = (longint'(req) + ALN - 1) / ALN * ALN + HDR;
    pick = -1; u = -1;
    for (int i = 0; i < NFREE; i++)
      if (ext_live[i] && longint'(ext_len[i]) > amnt &&
          (pick < 0 || ext_base[i] < ext_base[pick])) pick = i;
    if (pick < 0) begin r.status = ffha_pkg::ST_NOFIT; return r; end
    for (int i = 0; i < NUSED; i++) if (!blk_live[i]) begin u = i; break; end
    if (u < 0) begin r.status = ffha_pkg::ST_FULL; return r; end
    blk_live[u] = 1'b1;
    blk_base[u] = ext_base[pick];
    blk_len[u]  = amnt[ffha_pkg::ADDR_W-1:0];
    ext_base[pick] = ext_base[pick] + amnt[ffha_pkg::ADDR_W-1:0];
    ext_len[pick]  = ext_len[pick] - amnt[ffha_pkg::ADDR_W-1:0];
    r.addr = ffha_pkg::DATA_W'(blk_base[u] + HDR);
    return r;
  endfunction

  function automatic ffha_pkg::status_t release_block(
      input logic [ffha_pkg::DATA_W-1:0] fa);
    int u, lft, rgt, s;
    logic [ffha_pkg::ADDR_W-1:0] b;
    logic [ffha_pkg::ADDR_W:0]   e;
    u = -1; lft = -1; rgt = -1;
    if (fa == 0) return ffha_pkg::ST_BADADDR;
    for (int i = 0; i < NUSED; i++)
      if (blk_live[i] && longint'(blk_base[i]) + HDR == longint'(fa)) begin
        u = i; break;
      end
    if (u < 0) return ffha_pkg::ST_BADADDR;
    b = blk_base[u];
    e = {1'b0, b} + {1'b0, blk_len[u]};
    for (int i = 0; i < NFREE; i++) begin
      if (!ext_live[i]) continue;
      // end sums are compared unmasked
      if (lft < 0 && 32'(ext_base[i]) + 32'(ext_len[i]) == 32'(b)) lft = i;
      else if (rgt < 0 && {1'b0, ext_base[i]} == e) rgt = i;
    end
    if (lft >= 0) begin
      ext_len[lft] = ext_len[lft] + blk_len[u];
      if (rgt >= 0) begin
        ext_len[lft] = ext_len[lft] + ext_len[rgt];
        ext_live[rgt] = 1'b0; ext_base[rgt] = '0; ext_len[rgt] = '0;
      end
    end else if (rgt >= 0) begin
      ext_base[rgt] = b;
      ext_len[rgt]  = ext_len[rgt] + blk_len[u];
    end else begin
      s = open_extent_slot();
      if (s < 0) return ffha_pkg::ST_FULL;
      ext_live[s] = 1'b1; ext_base[s] = b; ext_len[s] = blk_len[u];
    end
    blk_live[u] = 1'b0; blk_base[u] = '0; blk_len[u] = '0;
    return ffha_pkg::ST_OK;
  endfunction

  // predict on accepted requests, compare accepted results
  always @(posedge clk) begin
    heap_result_t want, got;
    if (!rst_n) begin
      reg_mem_start  <= ffha_pkg::RST_MEM_START;
      reg_hole_start <= ffha_pkg::RST_HOLE_START;
      reg_hole_end   <= ffha_pkg::RST_HOLE_END;
      reg_mem_end    <= ffha_pkg::RST_MEM_END;
      clear_tables();
      expected_results.delete();
      fail_count = 0;
      pending_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ffha_pkg::CFG_MEM_START:  reg_mem_start  <= cfg_data;
          ffha_pkg::CFG_HOLE_START: reg_hole_start <= cfg_data;
          ffha_pkg::CFG_HOLE_END:   reg_hole_end   <= cfg_data;
          ffha_pkg::CFG_MEM_END:    reg_mem_end    <= cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        want = '{addr: '0, status: ffha_pkg::ST_OK};
        case (in_tuser)
          ffha_pkg::OP_INIT: begin
            clear_tables();
            place_extent(reg_mem_start, reg_hole_start);
            place_extent(reg_hole_end, reg_mem_end);
          end
          ffha_pkg::OP_ALLOC: want = carve_block(in_tdata[22:0]);
          ffha_pkg::OP_FREE:  want.status = release_block(in_tdata[44:23]);
          default: ;
        endcase
        expected_results.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = '{addr: out_tdata[21:0], status: ffha_pkg::status_t'(out_tuser)};
        if (expected_results.size() == 0) report("result beat with nothing expected");
        else begin
          want = expected_results.pop_front();
          if (got.addr != want.addr)
            report($sformatf("data_addr %0h, expected %0h", got.addr, want.addr));
          if (got.status != want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
          if (out_tdata[23:22] != 2'b00) report("nonzero pad in out_tdata");
        end
      end
      pending_count = expected_results.size();
    end
  end

endmodule

### tb/sv/first_fit_heap_allocator_test.sv
`timescale 1ns / 1ps
module first_fit_heap_allocator_test;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [22:0] cfg_data = '0;
  int          fail_count;
  int          pending_count;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic [ffha_pkg::DATA_W-1:0] handed_out [$];

  always #2 clk = ~clk;

  first_fit_heap_allocator DUT (.*);

  first_fit_heap_allocator_checker checker_i (.*);

  // receiver stalls at random
  always @(negedge clk)
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);

  // valid stays up after a beat; the next beat or an idle cycle replaces it
  task automatic send_request(input ffha_pkg::op_t op, input logic [22:0] size,
                              input logic [21:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, addr, size};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [22:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_region(input logic [22:0] ms, input logic [22:0] hs,
                            input logic [22:0] he, input logic [22:0] me);
    drain();
    write_reg(ffha_pkg::CFG_MEM_START, ms);
    write_reg(ffha_pkg::CFG_HOLE_START, hs);
    write_reg(ffha_pkg::CFG_HOLE_END, he);
    write_reg(ffha_pkg::CFG_MEM_END, me);
    cfg_valid <= 1'b0;
    send_request(ffha_pkg::OP_INIT, 23'($urandom), 22'($urandom));
  endtask

  // mostly sane allocs and frees of live blocks, with some noise
  task automatic random_phase(input int count, input int big);
    logic [22:0] sz;
    int k, pick;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 2) send_request(ffha_pkg::OP_INIT, 23'($urandom), 22'($urandom));
      else if (pick < 4) send_request(ffha_pkg::op_t'(2'd3), 23'($urandom), 22'($urandom));
      else if (pick < 50) begin
        sz = big ? 23'($urandom)
                 : (($urandom_range(9) == 0) ? 23'($urandom_range(65536))
                                             : 23'($urandom_range(600)));
        send_request(ffha_pkg::OP_ALLOC, sz, 22'($urandom));
      end else if (pick < 90 && handed_out.size() > 0) begin
        pick = $urandom_range(handed_out.size() - 1);
        send_request(ffha_pkg::OP_FREE, 23'($urandom), handed_out[pick]);
        handed_out.delete(pick);
      end else send_request(ffha_pkg::OP_FREE, 23'($urandom),
                            ($urandom_range(1)) ? 22'($urandom) : 22'h0);
    end
  endtask

  // remember addresses that allocations hand out
  always @(posedge clk)
    if (out_tvalid && out_tready && out_tdata[21:0] != 0) handed_out.push_back(out_tdata[21:0]);

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // before init: nothing fits, frees are invalid
    send_request(ffha_pkg::OP_ALLOC, 23'd1, '0);
    send_request(ffha_pkg::OP_FREE, '0, 22'h0);
    send_request(ffha_pkg::OP_INIT, '1, '1);
    send_request(ffha_pkg::OP_ALLOC, 23'd0, '0);
    send_request(ffha_pkg::OP_ALLOC, 23'd15, '0);
    send_request(ffha_pkg::OP_ALLOC, 23'd16, '0);
    send_request(ffha_pkg::OP_ALLOC, 23'h7fffff, '0);
    send_request(ffha_pkg::OP_ALLOC, 23'd524272, '0);
    send_request(ffha_pkg::OP_FREE, '0, 22'h3fffff);
    send_request(ffha_pkg::OP_FREE, '0, 22'd131088);
    send_request(ffha_pkg::OP_FREE, '0, 22'd131088);
    send_request(ffha_pkg::OP_FREE, '0, 22'd131120);
    send_request(ffha_pkg::op_t'(2'd3), '1, '1);
    handed_out.delete();

    // empty and overlapping extents, tiny heap, wide top
    set_region(23'd256, 23'd128, 23'd0, 23'h7ffff0);
    send_request(ffha_pkg::OP_ALLOC, 23'd100, '0);
    send_request(ffha_pkg::OP_ALLOC, 23'h3ffff0, '0);
    send_request(ffha_pkg::OP_ALLOC, 23'h3fff00, '0);
    set_region(23'd4096, 23'd8192, 23'd6144, 23'd10240);
    send_request(ffha_pkg::OP_ALLOC, 23'd16, '0);
    send_request(ffha_pkg::OP_ALLOC, 23'd8000, '0);
    handed_out.delete();

    // table pressure: small heap fills used table, fragmentation fills free
    set_region(23'd16, 23'd2048, 23'd4096, 23'd16384);
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      random_phase(130, 0);
      if (p == 3) begin
        handed_out.delete();
        set_region(23'h000010, 23'h100000, 23'h100000, 23'h7ffff0);
      end
    end
    handed_out.delete();
    set_region(ffha_pkg::RST_MEM_START, ffha_pkg::RST_HOLE_START,
               ffha_pkg::RST_HOLE_END, ffha_pkg::RST_MEM_END);
    random_phase(60, 1);
    drain();
    if (fail_count == 0) $display("PASS first_fit_heap_allocator");
    else $display("FAIL first_fit_heap_allocator");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL first_fit_heap_allocator");
    $finish;
  end

endmodule
